@@ hw/rtl/pip_pkg.sv @@
package pip_pkg;

  // Field widths of the stream words
  localparam int COORD_W  = 32;
  localparam int SLOT_W   = 4;
  localparam int CFG_W    = 5;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;

  // Input tdata layout: vertex_index, x_coord, y_coord, zero pad to bytes
  localparam int SLOT_LSB = 0;
  localparam int X_LSB    = SLOT_LSB + SLOT_W;
  localparam int Y_LSB    = X_LSB + COORD_W;
  localparam int IN_RAW_W = Y_LSB + COORD_W;
  localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  localparam int DEF_MAX_VERTICES = 16;

  // Action codes carried on tuser
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Query point and running crossing parity passed down the chain
  typedef struct packed {
    logic                       parity;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
  } point_t;

endpackage

@@ hw/rtl/point_in_polygon_test_top.sv @@
// Even-odd point-in-polygon test over a chain of edge cells.
// Input stream (s_axis): tuser selects the word kind. A load word writes one
// corner into the cell at vertex_index and gives no result; a query word
// carries a point and gives one result word on m_axis, bit 0 = inside.
// cfg_wr_en_i / cfg_wr_data_i set the number of corners in use (saturates at
// MAX_VERTICES); write it only while no query is pending.
// Each cell owns one corner and tests the edge from the previous corner to its
// own (cell 0 takes the closing edge from the last corner in use). A query
// walks the chain, two register stages per cell (multiply, then compare), so
// its result is the parity held in the last cell's compare register. Queries enter one
// per cycle back to back unless the output stalls. A load is held off until
// every pending query result has been taken, as the chain reads the corners.
// When m_axis_tready is low with a result waiting, the whole chain holds and
// s_axis_tready drops. Reset empties the chain, clears the corner count to 0
// and leaves the corner registers undefined until loaded.
module point_in_polygon_test_top #(
  parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_wr_en_i,
  input  logic [pip_pkg::CFG_W-1:0]         cfg_wr_data_i,     // vertex_count
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [3:0] vertex_index, [35:4] x_coord, [67:36] y_coord, [71:68] zero
  input  logic [pip_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tuser,      // [0] action
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [pip_pkg::OUT_TDATA_W-1:0]   m_axis_tdata       // [0] inside_res, [7:1] zero
);

  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int FLY_W  = $clog2(2 * MAX_VERTICES + 1);

  logic [pip_pkg::CFG_W-1:0]  cfg_q;
  logic [CNT_W-1:0]           n_used;
  logic [IDX_W-1:0]           last_idx;
  logic [FLY_W-1:0]           fly_q, fly_d;
  logic                       adv, is_query, in_acc, out_acc, q_acc, ld_acc, ld_ok;
  logic [pip_pkg::SLOT_W-1:0] slot;
  logic signed [pip_pkg::COORD_W-1:0] in_x, in_y;

  logic                               chain_valid [MAX_VERTICES+1];
  pip_pkg::point_t                    chain_tok   [MAX_VERTICES+1];
  logic signed [pip_pkg::COORD_W-1:0] vert_x [MAX_VERTICES];
  logic signed [pip_pkg::COORD_W-1:0] vert_y [MAX_VERTICES];

  // Field unpacking
  assign slot = s_axis_tdata[pip_pkg::SLOT_LSB +: pip_pkg::SLOT_W];
  assign in_x = s_axis_tdata[pip_pkg::X_LSB +: pip_pkg::COORD_W];
  assign in_y = s_axis_tdata[pip_pkg::Y_LSB +: pip_pkg::COORD_W];

  // Handshake: chain moves unless a finished result is stalled
  assign adv      = !m_axis_tvalid || m_axis_tready;
  assign is_query = (s_axis_tuser == pip_pkg::ACT_QUERY);
  assign s_axis_tready = is_query ? adv : (fly_q == '0);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign q_acc    = in_acc && is_query;
  assign ld_acc   = in_acc && !is_query;
  assign ld_ok    = 32'(slot) < MAX_VERTICES;
  assign out_acc  = m_axis_tvalid && m_axis_tready;

  // Corner count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr_en_i) begin
      cfg_q <= cfg_wr_data_i;
    end
  end

  assign n_used   = (32'(cfg_q) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : CNT_W'(cfg_q);
  assign last_idx = IDX_W'(n_used - CNT_W'(1));

  // Queries in flight
  always_comb begin
    fly_d = fly_q;
    if (q_acc && !out_acc) begin
      fly_d = fly_q + FLY_W'(1);
    end else if (!q_acc && out_acc) begin
      fly_d = fly_q - FLY_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fly_q <= '0;
    end else begin
      fly_q <= fly_d;
    end
  end

  // Chain entry
  assign chain_valid[0] = q_acc;
  assign chain_tok[0]   = '{parity: 1'b0, px: in_x, py: in_y};

  // Row of edge cells
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    logic signed [pip_pkg::COORD_W-1:0] prev_x, prev_y;

    if (k == 0) begin : g_close
      assign prev_x = vert_x[last_idx];
      assign prev_y = vert_y[last_idx];
    end else begin : g_link
      assign prev_x = vert_x[k-1];
      assign prev_y = vert_y[k-1];
    end

    pip_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .wr_en_i   (ld_acc && ld_ok && (32'(slot) == k)),
      .wr_x_i    (in_x),
      .wr_y_i    (in_y),
      .edge_en_i (32'(n_used) > k),
      .prev_x_i  (prev_x),
      .prev_y_i  (prev_y),
      .vert_x_o  (vert_x[k]),
      .vert_y_o  (vert_y[k]),
      .valid_i   (chain_valid[k]),
      .tok_i     (chain_tok[k]),
      .valid_o   (chain_valid[k+1]),
      .tok_o     (chain_tok[k+1])
    );
  end

  // Last cell's register is the output word
  assign m_axis_tvalid = chain_valid[MAX_VERTICES];
  assign m_axis_tdata  = {(pip_pkg::OUT_TDATA_W-1)'(0), chain_tok[MAX_VERTICES].parity};

  // Checks
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_acc |-> (fly_q == '0))
    else $error("load word taken with queries in flight");

  a_out_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (fly_q != '0))
    else $error("result word with no query in flight");

  a_fly_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fly_q) <= 2 * MAX_VERTICES)
    else $error("in-flight count exceeds chain depth");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (fly_q == $past(fly_q) + FLY_W'($past(q_acc))))
    else $error("in-flight count moved during stall");

endmodule

@@ hw/rtl/pip_cell.sv @@
module pip_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              wr_en_i,
  input  logic signed [pip_pkg::COORD_W-1:0] wr_x_i,
  input  logic signed [pip_pkg::COORD_W-1:0] wr_y_i,
  input  logic                              edge_en_i,
  input  logic signed [pip_pkg::COORD_W-1:0] prev_x_i,
  input  logic signed [pip_pkg::COORD_W-1:0] prev_y_i,
  output logic signed [pip_pkg::COORD_W-1:0] vert_x_o,
  output logic signed [pip_pkg::COORD_W-1:0] vert_y_o,
  input  logic                              valid_i,
  input  pip_pkg::point_t                   tok_i,
  output logic                              valid_o,
  output pip_pkg::point_t                   tok_o
);

  logic signed [pip_pkg::COORD_W-1:0] vx_q, vy_q;
  logic signed [pip_pkg::DIFF_W-1:0]  a_diff, c_diff, d_diff, dy;
  logic signed [pip_pkg::PROD_W-1:0]  p1_d, p2_d, p1_q, p2_q;
  logic                               straddle_d, straddle_q, dyneg_q;
  logic                               a_valid_q, b_valid_q;
  pip_pkg::point_t                    a_tok_q, b_tok_d, b_tok_q;
  logic                               toggle;

  // Own corner, written by a load word
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      vx_q <= wr_x_i;
      vy_q <= wr_y_i;
    end
  end

  assign vert_x_o = vx_q;
  assign vert_y_o = vy_q;

  // Edge from previous corner (j) to own corner (i): differences and cross products
  always_comb begin
    dy     = $signed({prev_y_i[pip_pkg::COORD_W-1], prev_y_i}) -
             $signed({vy_q[pip_pkg::COORD_W-1], vy_q});
    a_diff = $signed({tok_i.px[pip_pkg::COORD_W-1], tok_i.px}) -
             $signed({vx_q[pip_pkg::COORD_W-1], vx_q});
    c_diff = $signed({prev_x_i[pip_pkg::COORD_W-1], prev_x_i}) -
             $signed({vx_q[pip_pkg::COORD_W-1], vx_q});
    d_diff = $signed({tok_i.py[pip_pkg::COORD_W-1], tok_i.py}) -
             $signed({vy_q[pip_pkg::COORD_W-1], vy_q});
    p1_d   = a_diff * dy;
    p2_d   = c_diff * d_diff;
    straddle_d = edge_en_i & ((vy_q > tok_i.py) != (prev_y_i > tok_i.py));
  end

  // Crossing lies right of the point: sign of dy picks the compare direction
  always_comb begin
    toggle         = straddle_q & (dyneg_q ? (p1_q > p2_q) : (p1_q < p2_q));
    b_tok_d        = a_tok_q;
    b_tok_d.parity = a_tok_q.parity ^ toggle;
  end

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_tok_q    <= tok_i;
      p1_q       <= p1_d;
      p2_q       <= p2_d;
      straddle_q <= straddle_d;
      dyneg_q    <= dy[pip_pkg::DIFF_W-1];
      b_tok_q    <= b_tok_d;
    end
  end

  assign valid_o = b_valid_q;
  assign tok_o   = b_tok_q;

endmodule

@@ verif/tb_point_in_polygon_test_top.sv @@
`timescale 1ns / 100ps

module tb_point_in_polygon_test_top;
  import pip_pkg::*;

  localparam int MAXV           = DEF_MAX_VERTICES;
  localparam int LAT            = 2 * MAXV;
  localparam int DIR_ROWS       = 25;
  localparam int RAND_WORDS     = 1050;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  localparam coord_t CMIN = 32'sh8000_0000;
  localparam coord_t CMAX = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_COUNT} row_kind_e;

  // One directed step; a count row carries the new corner count in x
  typedef struct packed {
    row_kind_e   kind;
    logic [SLOT_W-1:0] slot;
    coord_t      x;
    coord_t      y;
    logic        known;
    logic        want;
  } dir_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_wr_en_i   = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Shadow copy of the corner table and count
  coord_t           corner_x [MAXV];
  coord_t           corner_y [MAXV];
  logic [CFG_W-1:0] poly_count = '0;

  logic inside_due_q [$];
  logic inside_want;
  int   err_cnt      = 0;
  int   words_sent   = 0;
  int   burst_left   = 0;
  int   stall_left   = 0;
  int   stall_mode   = 0;
  int   beat_cnt     = 0;
  int   quiet_cycles = 0;

  // Corner triangle scale
  localparam coord_t TA = 32'sh0010_0000;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // count 0 out of reset: always outside
    '{ROW_QUERY, 4'h0, 32'sh0, 32'sh0, 1'b1, 1'b0},
    '{ROW_QUERY, 4'h5, CMIN, CMAX, 1'b1, 1'b0},
    // full-range square
    '{ROW_LOAD, 4'h0, CMIN, CMIN, 1'b0, 1'b0},
    '{ROW_LOAD, 4'h1, CMAX, CMIN, 1'b0, 1'b0},
    '{ROW_LOAD, 4'h2, CMAX, CMAX, 1'b0, 1'b0},
    '{ROW_LOAD, 4'h3, CMIN, CMAX, 1'b0, 1'b0},
    // single corner: no edge can toggle
    '{ROW_COUNT, 4'h0, 32'sh1, 32'sh0, 1'b0, 1'b0},
    '{ROW_QUERY, 4'h0, 32'sh0, 32'sh0, 1'b1, 1'b0},
    '{ROW_COUNT, 4'h0, 32'sh4, 32'sh0, 1'b0, 1'b0},
    '{ROW_QUERY, 4'hF, 32'sh0, 32'sh0, 1'b1, 1'b1},
    // points on the square's border and extremes
    '{ROW_QUERY, 4'h0, CMIN, 32'sh0, 1'b0, 1'b0},
    '{ROW_QUERY, 4'h0, CMAX, 32'sh0, 1'b0, 1'b0},
    '{ROW_QUERY, 4'h0, 32'sh0, CMIN, 1'b0, 1'b0},
    '{ROW_QUERY, 4'h0, 32'sh0, CMAX, 1'b0, 1'b0},
    // two corners on one horizontal line
    '{ROW_COUNT, 4'h0, 32'sh2, 32'sh0, 1'b0, 1'b0},
    '{ROW_QUERY, 4'h0, 32'sh0, 32'sh0, 1'b1, 1'b0},
    // small triangle
    '{ROW_LOAD, 4'h0, 32'sh0, 32'sh0, 1'b0, 1'b0},
    '{ROW_LOAD, 4'h1, TA, 32'sh0020_0000, 1'b0, 1'b0},
    '{ROW_LOAD, 4'h2, 32'sh0020_0000, 32'sh0, 1'b0, 1'b0},
    '{ROW_COUNT, 4'h0, 32'sh3, 32'sh0, 1'b0, 1'b0},
    '{ROW_QUERY, 4'h7, TA, 32'sh0008_0000, 1'b1, 1'b1},
    '{ROW_QUERY, 4'h8, 32'shFFF0_0000, 32'sh0008_0000, 1'b1, 1'b0},
    // point on an edge, point on the apex
    '{ROW_QUERY, 4'h0, 32'sh0008_0000, TA, 1'b0, 1'b0},
    '{ROW_QUERY, 4'h0, TA, 32'sh0020_0000, 1'b0, 1'b0},
    '{ROW_LOAD, 4'hF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b0, 1'b0}
  };

  point_in_polygon_test_top #(
    .MAX_VERTICES (MAXV)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Even-odd crossing count over the corners in use, exact cross-multiply
  function automatic logic predict_inside(input coord_t px, input coord_t py);
    int    n;
    int    j;
    logic  par;
    diff_t dx, dy, ex, ey;
    prod_t lhs, rhs;
    logic  left;
    n   = (poly_count > MAXV) ? MAXV : int'(poly_count);
    par = 1'b0;
    j   = n - 1;
    for (int i = 0; i < n; i++) begin
      if ((corner_y[i] > py) != (corner_y[j] > py)) begin
        dx   = px - corner_x[i];
        dy   = corner_y[j] - corner_y[i];
        ex   = corner_x[j] - corner_x[i];
        ey   = py - corner_y[i];
        lhs  = dx * dy;
        rhs  = ex * ey;
        left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
        if (left) par = ~par;
      end
      j = i;
    end
    return par;
  endfunction

  // Signed value in [-2^k, 2^k)
  function automatic coord_t rand_coord(input int k);
    return coord_t'($signed($urandom) >>> (31 - k));
  endfunction

  function automatic coord_t ext_coord();
    case ($urandom_range(0, 4))
      0: return CMIN;
      1: return CMAX;
      2: return '0;
      3: return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Drive one word in bursts with random gaps; returns at the accepting edge
  task automatic send_word(input logic act, input logic [SLOT_W-1:0] slot,
                           input coord_t x, input coord_t y,
                           input logic known, input logic want);
    logic [IN_TDATA_W-1:0] word;
    int                    gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    word                         = '0;
    word[SLOT_LSB +: SLOT_W]     = slot;
    word[X_LSB +: COORD_W]       = x;
    word[Y_LSB +: COORD_W]       = y;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (act == ACT_LOAD) begin
      corner_x[slot] = x;
      corner_y[slot] = y;
    end else begin
      inside_due_q = {inside_due_q, (known ? want : predict_inside(x, y))};
    end
    words_sent++;
  endtask

  // Change the corner count once the chain has drained
  task automatic set_count(input logic [CFG_W-1:0] cnt);
    s_axis_tvalid <= 1'b0;
    while (inside_due_q.size() != 0) @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= cnt;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    poly_count  = cnt;
    burst_left  = 0;
  endtask

  // New count, fresh polygon over the slots in use, then a stream of queries with occasional corner rewrites
  task automatic run_phase(input logic [CFG_W-1:0] cnt);
    int     n, k, n_q, pick, a, b;
    int     order [$];
    coord_t vx, vy, qx, qy;
    set_count(cnt);
    n = (cnt > MAXV) ? MAXV : int'(cnt);
    case ($urandom_range(0, 4))
      0: k = 3;
      1: k = 8;
      2: k = 16;
      3: k = 24;
      default: k = 31;
    endcase
    for (int s = 0; s < n; s++) order = {order, s};
    if ($urandom_range(0, 3) == 0) order.shuffle();
    vx = rand_coord(k);
    vy = rand_coord(k);
    foreach (order[o]) begin
      case ($urandom_range(0, 7))
        0: vx = rand_coord(k);   // keeps y: horizontal edge
        1: vy = rand_coord(k);
        2: ;                     // repeated corner
        3: begin
          vx = ext_coord();
          vy = ext_coord();
        end
        default: begin
          vx = rand_coord(k);
          vy = rand_coord(k);
        end
      endcase
      send_word(ACT_LOAD, SLOT_W'(order[o]), vx, vy, 1'b0, 1'b0);
    end
    n_q = $urandom_range(12, 60);
    repeat (n_q) begin
      a    = (n == 0) ? 0 : $urandom_range(0, n - 1);
      b    = (a + 1 >= n) ? 0 : a + 1;
      pick = $urandom_range(0, 15);
      qx   = rand_coord(k);
      qy   = rand_coord(k);
      if (pick == 0) begin
        // rewrite a corner between queries
        send_word(ACT_LOAD, SLOT_W'($urandom_range(0, MAXV - 1)), qx, qy, 1'b0, 1'b0);
      end else begin
        case (pick)
          1, 2: qy = corner_y[a];
          3: begin
            qx = corner_x[a];
            qy = corner_y[a];
          end
          4, 5: begin
            qx = coord_t'((longint'(corner_x[a]) + longint'(corner_x[b])) >>> 1);
            qy = coord_t'((longint'(corner_y[a]) + longint'(corner_y[b])) >>> 1);
          end
          6: begin
            qx = ext_coord();
            qy = ext_coord();
          end
          7: begin
            qx = coord_t'($urandom);
            qy = coord_t'($urandom);
          end
          default: ;
        endcase
        send_word(ACT_QUERY, SLOT_W'($urandom), qx, qy, 1'b0, 1'b0);
      end
    end
  endtask

  // Result check and receiver stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (inside_due_q.size() == 0) begin
        $error("inside_res: no query pending, expected none, got %0b", m_axis_tdata[0]);
        err_cnt++;
      end else begin
        inside_want = inside_due_q.pop_front();
        if (m_axis_tdata[0] !== inside_want) begin
          $error("inside_res: expected %0b, got %0b", inside_want, m_axis_tdata[0]);
          err_cnt++;
        end
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 90);
    end
    stall_left--;
    beat_cnt++;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (beat_cnt % 4) != 3;
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[r]) begin
      case (dir_tab[r].kind)
        ROW_COUNT: set_count(dir_tab[r].x[CFG_W-1:0]);
        ROW_LOAD:  send_word(ACT_LOAD, dir_tab[r].slot, dir_tab[r].x, dir_tab[r].y,
                             1'b0, 1'b0);
        default:   send_word(ACT_QUERY, dir_tab[r].slot, dir_tab[r].x, dir_tab[r].y,
                             dir_tab[r].known, dir_tab[r].want);
      endcase
    end

    // saturated count, full table, empty polygon, then random counts
    run_phase(5'd31);
    run_phase(5'd16);
    run_phase(5'd0);
    while (words_sent < DIR_ROWS + RAND_WORDS) begin
      case ($urandom_range(0, 9))
        0: run_phase(5'd0);
        1: run_phase(5'd1);
        2: run_phase(5'd2);
        3: run_phase(5'd16);
        4: run_phase(CFG_W'($urandom_range(17, 31)));
        default: run_phase(CFG_W'($urandom_range(3, 15)));
      endcase
    end

    s_axis_tvalid <= 1'b0;
    while (inside_due_q.size() != 0) @(posedge clk_i);
    repeat (LAT + 8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/pip_pkg.sv
hw/rtl/pip_cell.sv
hw/rtl/point_in_polygon_test_top.sv
verif/tb_point_in_polygon_test_top.sv
